>>> design/double_ended_queue_unit_defines.svh
// Assertion macros shared by the double-ended queue RTL.
// Needs a clock named clk and an active-low reset named arst_n in the using module.
`ifndef DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_UNIT_DEFINES_SVH

// Condition must hold at every clock edge outside reset.
`define DEQ_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// When ante holds, cons must hold in the next cycle.
`define DEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/deq_pkg.sv
// Shared types and constants for the double-ended queue.
// No dependencies; used by deq_ctrl and double_ended_queue_unit.
package deq_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int WORD_W         = 32;
	localparam int ENTRIES_W      = 5;

	typedef enum logic [1:0] {
		OP_ADD_FRONT = 2'd0,
		OP_ADD_BACK  = 2'd1,
		OP_REM_FRONT = 2'd2,
		OP_REM_BACK  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// request beat
	typedef struct packed {
		op_t               operation;
		logic [WORD_W-1:0] data_in;
	} req_t;

	// response beat
	typedef struct packed {
		logic [WORD_W-1:0]    data_out;
		status_t              status;
		logic [ENTRIES_W-1:0] entries;
	} rsp_t;

	// per-request result info from control to the response path
	typedef struct packed {
		status_t              status;
		logic [ENTRIES_W-1:0] entries;
		logic                 has_data;
	} ctl_t;

endpackage

>>> design/deq_ram.sv
// Slot storage: one write port, one read port, registered read data.
// Depends on nothing but its parameters.
module deq_ram #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32,
	localparam int ADDR_W    = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [ADDR_W-1:0]     wr_addr,
	input  logic [DATA_WIDTH-1:0] wr_data,
	input  logic                  rd_en,
	input  logic [ADDR_W-1:0]     rd_addr,
	output logic [DATA_WIDTH-1:0] rd_data
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];
	logic [DATA_WIDTH-1:0] rd_data_q;

	// write and synchronous read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> design/deq_ctrl.sv
// Front index and entry count, request decode and slot addressing.
// Depends on deq_pkg and the assertion macros header.
`include "double_ended_queue_unit_defines.svh"

module deq_ctrl #(
	parameter int DEPTH      = 16,
	parameter int DATA_WIDTH = 32,
	localparam int ADDR_W    = $clog2(DEPTH)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  deq_pkg::req_t         req,
	output logic                  wr_en,
	output logic [ADDR_W-1:0]     wr_addr,
	output logic [DATA_WIDTH-1:0] wr_data,
	output logic                  rd_en,
	output logic [ADDR_W-1:0]     rd_addr,
	output deq_pkg::ctl_t         info
);

	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int SUM_W = CNT_W + 1;

	logic [ADDR_W-1:0] front_q, front_d;
	logic [CNT_W-1:0]  count_q, count_d;

	logic              full, empty;
	logic [ADDR_W-1:0] front_dec, front_inc, back_addr, last_addr;
	logic [SUM_W-1:0]  back_sum, last_sum;

	// ring positions, wrapped by one compare and subtract
	always_comb begin
		full      = (count_q == CNT_W'(DEPTH));
		empty     = (count_q == '0);
		front_dec = (front_q == '0) ? ADDR_W'(DEPTH - 1) : front_q - ADDR_W'(1);
		front_inc = (front_q == ADDR_W'(DEPTH - 1)) ? '0 : front_q + ADDR_W'(1);
		back_sum  = SUM_W'(front_q) + SUM_W'(count_q);
		last_sum  = back_sum - SUM_W'(1);
		back_addr = (back_sum >= SUM_W'(DEPTH)) ? ADDR_W'(back_sum - SUM_W'(DEPTH))
		                                       : ADDR_W'(back_sum);
		last_addr = (last_sum >= SUM_W'(DEPTH)) ? ADDR_W'(last_sum - SUM_W'(DEPTH))
		                                       : ADDR_W'(last_sum);
	end

	// decode the operation
	always_comb begin
		front_d       = front_q;
		count_d       = count_q;
		wr_en         = 1'b0;
		wr_addr       = back_addr;
		rd_en         = 1'b0;
		rd_addr       = front_q;
		info.status   = deq_pkg::ST_DONE;
		info.has_data = 1'b0;
		unique case (req.operation)
			deq_pkg::OP_ADD_FRONT: begin
				if (full) begin
					info.status = deq_pkg::ST_FULL;
				end else begin
					wr_en   = accept;
					wr_addr = front_dec;
					front_d = front_dec;
					count_d = count_q + CNT_W'(1);
				end
			end
			deq_pkg::OP_ADD_BACK: begin
				if (full) begin
					info.status = deq_pkg::ST_FULL;
				end else begin
					wr_en   = accept;
					count_d = count_q + CNT_W'(1);
				end
			end
			deq_pkg::OP_REM_FRONT: begin
				if (empty) begin
					info.status = deq_pkg::ST_EMPTY;
				end else begin
					rd_en         = accept;
					info.has_data = 1'b1;
					front_d       = front_inc;
					count_d       = count_q - CNT_W'(1);
				end
			end
			deq_pkg::OP_REM_BACK: begin
				if (empty) begin
					info.status = deq_pkg::ST_EMPTY;
				end else begin
					rd_en         = accept;
					rd_addr       = last_addr;
					info.has_data = 1'b1;
					count_d       = count_q - CNT_W'(1);
				end
			end
		endcase
		info.entries = deq_pkg::ENTRIES_W'(count_d);
	end

	assign wr_data = DATA_WIDTH'(req.data_in);

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			front_q <= front_d;
			count_q <= count_d;
		end
	end

	`DEQ_ASSERT_ALWAYS(a_count_bound, count_q <= CNT_W'(DEPTH), "entry count above depth")
	`DEQ_ASSERT_NEXT(a_idle_hold, !accept, $stable(count_q) && $stable(front_q), "state moved while idle")
	`DEQ_ASSERT_NEXT(a_full_drop, accept && full && (req.operation == deq_pkg::OP_ADD_FRONT || req.operation == deq_pkg::OP_ADD_BACK), $stable(count_q) && $stable(front_q), "add on full changed state")
	`DEQ_ASSERT_NEXT(a_remove_dec, accept && rd_en, count_q == $past(count_q) - CNT_W'(1), "remove did not lower count")

endmodule

>>> design/double_ended_queue_unit.sv
// Bounded double-ended queue: request channel in, one response per request out.
// Usage:
//   Each request beat names an operation (add front, add back, remove front,
//   remove back) and a data word. Each request yields exactly one response
//   beat with the removed word (zero if none), a status (done, empty on
//   remove, full on add) and the entry count after the operation.
//   Responses come out in request order.
// Pipeline and throughput:
//   A request passes the slot read (at the accepting edge), then the response
//   register. One request per cycle is sustained while req_stall is low; the
//   slot memory does one write or one read per request and the index/count
//   registers update in the accepting cycle, so consecutive requests see
//   each other's effect.
// Reset:
//   arst_n clears the front index, entry count and all valid flags; the
//   queue is empty afterwards. Slot contents are not cleared.
// Stall:
//   While rsp_stall holds, the response beat stays put; one more request
//   can be taken into the middle stage, then req_stall rises.
// Depends on deq_pkg, deq_ctrl and deq_ram.
module double_ended_queue_unit #(
	parameter int DEPTH      = deq_pkg::DEPTH_DEF,
	parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  deq_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output deq_pkg::rsp_t  rsp
);

	localparam int ADDR_W = $clog2(DEPTH);

	logic                  accept, advance;
	logic                  wr_en, rd_en;
	logic [ADDR_W-1:0]     wr_addr, rd_addr;
	logic [DATA_WIDTH-1:0] wr_data, rd_data;
	deq_pkg::ctl_t         info;

	logic                  valid_s1;
	deq_pkg::ctl_t         info_s1;
	logic                  rsp_valid_q;
	deq_pkg::rsp_t         rsp_q;

	// handshake
	assign advance   = !rsp_valid_q || !rsp_stall;
	assign req_stall = valid_s1 && !advance;
	assign accept    = req_valid && !req_stall;

	deq_ctrl #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.req     (req),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.info    (info)
	);

	deq_ram #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// stage 1 valid: waits here for the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1 <= info;
		end
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			rsp_q.data_out <= info_s1.has_data ? deq_pkg::WORD_W'(rd_data) : '0;
			rsp_q.status   <= info_s1.status;
			rsp_q.entries  <= info_s1.entries;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
